FILE: rtl/lhm_pkg.sv
package lhm_pkg;

  // Histogram geometry.
  localparam int unsigned BINS         = 1001;
  localparam int unsigned BIN_WIDTH_US = 1000;

  localparam int unsigned BIN_AW = $clog2(BINS);
  // Counter width that can also hold BINS itself.
  localparam int unsigned BIN_CW = BIN_AW + 1;

  localparam logic [BIN_AW-1:0] LAST_BIN    = BIN_AW'(BINS - 1);
  localparam logic [BIN_CW-1:0] LAST_BIN_CNT = BIN_CW'(BINS - 1);
  localparam logic [BIN_CW-1:0] BINS_CNT     = BIN_CW'(BINS);

  localparam logic [31:0] BIN_W  = 32'(BIN_WIDTH_US);
  // RTTs at or above this value land in the last bin.
  localparam logic [31:0] CLAMP_US = 32'(64'(BINS - 1) * 64'(BIN_WIDTH_US));
  // floor(2^32 / BIN_WIDTH_US): the quotient estimate is low by at most one.
  localparam logic [32:0] RECIP_M = 33'((64'd1 << 32) / 64'(BIN_WIDTH_US));

  localparam logic [6:0] PCT_SCALE = 7'd100;
  localparam int unsigned SCL_W = 32 + 7;
  localparam int unsigned SUM_W = SCL_W + BIN_AW;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_OUTAGE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC_MUL,
    ST_REC_IDX,
    ST_REC_UPD,
    ST_Q_TGT,
    ST_Q_WALK,
    ST_Q_DONE,
    ST_FINISH
  } state_e;

endpackage

FILE: rtl/latency_histogram_monitor_core.sv
// A record result is set by the reciprocal divide and the read-modify-write of one histogram
// bin in the RAM, through the states REC_MUL, REC_IDX and REC_UPD.
// Outage and unused items answer from the FINISH state. A query walks the bin RAM one read
// per cycle and answers from Q_DONE.
// One item is in flight at a time; the result register lets the next item enter early.
// After reset the block zeroes every bin of the RAM before it takes items.
module latency_histogram_monitor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] seq_i,
  input  logic [31:0] rtt_us_i,
  input  logic [6:0]  percent_i,
  input  logic [51:0] now_us_i,
  input  logic [1:0]  event_reason_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] percentile_value_us_o,
  output logic [31:0] received_count_o,
  output logic [31:0] max_rtt_o,
  output logic [31:0] reconnect_count_o,
  output logic        recovered_o,
  output logic [51:0] downtime_us_o,
  output logic [1:0]  recovered_reason_o,
  output logic        outage_opened_o
);

  lhm_pkg::state_e state_q, state_d;

  // Latched item.
  logic [1:0]  op_q;
  logic [31:0] rtt_q;
  logic [6:0]  pct_q;
  logic [51:0] now_q;
  logic [1:0]  reason_q;

  // Monitor state.
  logic [31:0] match_total_q, rtt_peak_q, last_matched_q, recoveries_q;
  logic        seen_any_q, outage_open_q;
  logic [51:0] outage_begin_q;
  logic [1:0]  outage_cause_q;

  // Record path.
  logic [64:0]                 prod_q;
  logic                        big_q;
  logic [lhm_pkg::BIN_AW-1:0]  bin_q, bin_d, quo_est;
  logic [31:0]                 rem;

  // Query walk.
  logic [lhm_pkg::BIN_CW-1:0]    idx_q;
  logic [lhm_pkg::SCL_W-1:0]     tgt_q, scaled_q;
  logic [lhm_pkg::SUM_W-1:0]     sum_q, acc;
  logic                          v1_q, v2_q;
  logic [lhm_pkg::BIN_AW-1:0]    idx1_q, idx2_q, hit_idx_q;
  logic                          use_peak_q;
  logic                          walk_hit, walk_end;

  // RAM port.
  logic                       ram_we, ram_re;
  logic [lhm_pkg::BIN_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]                ram_wdata, ram_rdata;

  // Result register.
  logic        out_valid_q;
  logic [31:0] pval_q, rcv_q, peak_o_q, recon_q;
  logic        rec_q, opened_q;
  logic [51:0] down_q;
  logic [1:0]  rreason_q;

  logic        out_free, load_out, accept;
  logic [31:0] peak_new;
  logic        open_now;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;
  assign peak_new = (rtt_q > rtt_peak_q) ? rtt_q : rtt_peak_q;
  assign open_now = (op_q == lhm_pkg::OP_OUTAGE) && seen_any_q && !outage_open_q;

  // Quotient estimate from the reciprocal product, then one correction step.
  assign quo_est = prod_q[32 +: lhm_pkg::BIN_AW];
  assign rem     = rtt_q - 32'(32'(quo_est) * lhm_pkg::BIN_W);

  always_comb begin
    if (big_q) begin
      bin_d = lhm_pkg::LAST_BIN;
    end else if (rem >= lhm_pkg::BIN_W) begin
      bin_d = quo_est + 1'b1;
    end else begin
      bin_d = quo_est;
    end
  end

  // The walk compares 100 * running count against received * percent,
  // which equals the ceiling test without a divide.
  assign acc      = sum_q + lhm_pkg::SUM_W'(scaled_q);
  assign walk_hit = v2_q && (acc >= lhm_pkg::SUM_W'(tgt_q));
  assign walk_end = v2_q && (idx2_q == lhm_pkg::LAST_BIN) && !walk_hit;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lhm_pkg::ST_CLEAR: begin
        if (idx_q == lhm_pkg::LAST_BIN_CNT) state_d = lhm_pkg::ST_IDLE;
      end
      lhm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (operation_i)
            lhm_pkg::OP_RECORD: state_d = lhm_pkg::ST_REC_MUL;
            lhm_pkg::OP_QUERY:  state_d = lhm_pkg::ST_Q_TGT;
            default:            state_d = lhm_pkg::ST_FINISH;
          endcase
        end
      end
      lhm_pkg::ST_REC_MUL: state_d = lhm_pkg::ST_REC_IDX;
      lhm_pkg::ST_REC_IDX: state_d = lhm_pkg::ST_REC_UPD;
      lhm_pkg::ST_REC_UPD: begin
        if (out_free) state_d = lhm_pkg::ST_IDLE;
      end
      lhm_pkg::ST_Q_TGT: begin
        if (match_total_q == '0) begin
          state_d = lhm_pkg::ST_Q_DONE;
        end else begin
          state_d = lhm_pkg::ST_Q_WALK;
        end
      end
      lhm_pkg::ST_Q_WALK: begin
        if (walk_hit || walk_end) state_d = lhm_pkg::ST_Q_DONE;
      end
      lhm_pkg::ST_Q_DONE: begin
        if (out_free) state_d = lhm_pkg::ST_IDLE;
      end
      lhm_pkg::ST_FINISH: begin
        if (out_free) state_d = lhm_pkg::ST_IDLE;
      end
      default: state_d = lhm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = bin_q;
    ram_wdata  = ram_rdata + 32'd1;
    ram_re     = 1'b0;
    ram_raddr  = idx_q[lhm_pkg::BIN_AW-1:0];
    load_out   = 1'b0;
    case (state_q)
      lhm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[lhm_pkg::BIN_AW-1:0];
        ram_wdata = '0;
      end
      lhm_pkg::ST_IDLE: in_ready_o = 1'b1;
      lhm_pkg::ST_REC_IDX: begin
        ram_re    = 1'b1;
        ram_raddr = bin_d;
      end
      lhm_pkg::ST_REC_UPD: begin
        ram_we   = out_free;
        load_out = out_free;
      end
      lhm_pkg::ST_Q_WALK: ram_re = (idx_q < lhm_pkg::BINS_CNT);
      lhm_pkg::ST_Q_DONE: load_out = out_free;
      lhm_pkg::ST_FINISH: load_out = out_free;
      default: ;
    endcase
  end

  lhm_ram #(
    .WIDTH(32),
    .DEPTH(lhm_pkg::BINS)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Control and monitor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= lhm_pkg::ST_CLEAR;
      idx_q          <= '0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      out_valid_q    <= 1'b0;
      match_total_q  <= '0;
      rtt_peak_q     <= '0;
      last_matched_q <= '0;
      recoveries_q   <= '0;
      seen_any_q     <= 1'b0;
      outage_open_q  <= 1'b0;
      outage_begin_q <= '0;
      outage_cause_q <= '0;
    end else begin
      state_q <= state_d;

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        lhm_pkg::ST_CLEAR: idx_q <= idx_q + 1'b1;
        lhm_pkg::ST_Q_TGT: begin
          idx_q <= '0;
          v1_q  <= 1'b0;
          v2_q  <= 1'b0;
        end
        lhm_pkg::ST_Q_WALK: begin
          if (ram_re) idx_q <= idx_q + 1'b1;
          v1_q <= ram_re;
          v2_q <= v1_q;
        end
        default: ;
      endcase

      if (accept && (operation_i == lhm_pkg::OP_RECORD)) begin
        last_matched_q <= seq_i;
      end

      if ((state_q == lhm_pkg::ST_REC_UPD) && out_free) begin
        match_total_q <= match_total_q + 32'd1;
        rtt_peak_q    <= peak_new;
        seen_any_q    <= 1'b1;
        if (outage_open_q) begin
          recoveries_q  <= recoveries_q + 32'd1;
          outage_open_q <= 1'b0;
        end
      end

      if ((state_q == lhm_pkg::ST_FINISH) && out_free && open_now) begin
        outage_open_q  <= 1'b1;
        outage_begin_q <= now_q;
        outage_cause_q <= reason_q;
      end
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      rtt_q    <= rtt_us_i;
      pct_q    <= percent_i;
      now_q    <= now_us_i;
      reason_q <= event_reason_i;
    end

    if (state_q == lhm_pkg::ST_REC_MUL) begin
      prod_q <= 65'(rtt_q) * 65'(lhm_pkg::RECIP_M);
      big_q  <= (rtt_q >= lhm_pkg::CLAMP_US);
    end
    if (state_q == lhm_pkg::ST_REC_IDX) begin
      bin_q <= bin_d;
    end

    if (state_q == lhm_pkg::ST_Q_TGT) begin
      tgt_q      <= lhm_pkg::SCL_W'(match_total_q) * lhm_pkg::SCL_W'(pct_q);
      sum_q      <= '0;
      hit_idx_q  <= '0;
      use_peak_q <= 1'b0;
    end
    if (state_q == lhm_pkg::ST_Q_WALK) begin
      idx1_q   <= idx_q[lhm_pkg::BIN_AW-1:0];
      idx2_q   <= idx1_q;
      scaled_q <= lhm_pkg::SCL_W'(ram_rdata) * lhm_pkg::SCL_W'(lhm_pkg::PCT_SCALE);
      if (v2_q) sum_q <= acc;
      if (walk_hit) hit_idx_q <= idx2_q;
      if (walk_end) use_peak_q <= 1'b1;
    end

    if (load_out) begin
      pval_q    <= '0;
      rcv_q     <= match_total_q;
      peak_o_q  <= rtt_peak_q;
      recon_q   <= recoveries_q;
      rec_q     <= 1'b0;
      down_q    <= '0;
      rreason_q <= '0;
      opened_q  <= 1'b0;
      case (state_q)
        lhm_pkg::ST_REC_UPD: begin
          rcv_q    <= match_total_q + 32'd1;
          peak_o_q <= peak_new;
          if (outage_open_q) begin
            recon_q   <= recoveries_q + 32'd1;
            rec_q     <= 1'b1;
            down_q    <= now_q - outage_begin_q;
            rreason_q <= outage_cause_q;
          end
        end
        lhm_pkg::ST_Q_DONE: begin
          if (use_peak_q) begin
            pval_q <= rtt_peak_q;
          end else begin
            pval_q <= 32'(64'(hit_idx_q) * 64'(lhm_pkg::BIN_WIDTH_US));
          end
        end
        lhm_pkg::ST_FINISH: opened_q <= open_now;
        default: ;
      endcase
    end
  end

  assign out_valid_o           = out_valid_q;
  assign percentile_value_us_o = pval_q;
  assign received_count_o      = rcv_q;
  assign max_rtt_o             = peak_o_q;
  assign reconnect_count_o     = recon_q;
  assign recovered_o           = rec_q;
  assign downtime_us_o         = down_q;
  assign recovered_reason_o    = rreason_q;
  assign outage_opened_o       = opened_q;

  // No item enters while the bin RAM is being zeroed.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lhm_pkg::ST_CLEAR) |-> !in_ready_o)
    else $error("item accepted during bin clearing");

  // A finished record advances the match count by exactly one.
  a_record_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lhm_pkg::ST_REC_UPD) && out_free)
      |=> (match_total_q == $past(match_total_q) + 32'd1))
    else $error("match count did not advance on record");

  // An outage can only be open after a first match.
  a_outage_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outage_open_q |-> seen_any_q)
    else $error("outage open before any match");

  // Every histogram write stays inside the bin range.
  a_bin_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr <= lhm_pkg::LAST_BIN))
    else $error("bin write out of range");

  // The result register is never overwritten while a result waits.
  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !load_out)
    else $error("result overwritten before it was taken");

endmodule

FILE: rtl/lhm_ram.sv
module lhm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/sv/latency_histogram_monitor_core_tb.sv
`timescale 1ns / 1ps

module latency_histogram_monitor_core_tb;

  localparam logic [1:0] OP_UNUSED         = 2'd3;
  localparam logic [1:0] RSN_LINK_DOWN     = 2'd0;
  localparam logic [1:0] RSN_SEND_FAIL     = 2'd1;
  localparam logic [1:0] RSN_PROBE_TIMEOUT = 2'd2;
  localparam logic [1:0] RSN_UNDEFINED     = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 10000000;
  localparam int unsigned SETTLE_CYCLES = lhm_pkg::BINS + 50;
  localparam int unsigned MAX_PRINTED   = 50;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] seq;
    logic [31:0] rtt;
    logic [6:0]  pct;
    logic [51:0] now;
    logic [1:0]  reason;
  } probe_item_t;

  typedef struct packed {
    logic [31:0] pctl_us;
    logic [31:0] rx_count;
    logic [31:0] peak_rtt;
    logic [31:0] reconnects;
    logic        recovered;
    logic [51:0] downtime;
    logic [1:0]  rec_reason;
    logic        opened;
  } monitor_stats_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [31:0] seq_i;
  logic [31:0] rtt_us_i;
  logic [6:0]  percent_i;
  logic [51:0] now_us_i;
  logic [1:0]  event_reason_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] percentile_value_us_o;
  logic [31:0] received_count_o;
  logic [31:0] max_rtt_o;
  logic [31:0] reconnect_count_o;
  logic        recovered_o;
  logic [51:0] downtime_us_o;
  logic [1:0]  recovered_reason_o;
  logic        outage_opened_o;

  latency_histogram_monitor_core u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .operation_i           (operation_i),
    .seq_i                 (seq_i),
    .rtt_us_i              (rtt_us_i),
    .percent_i             (percent_i),
    .now_us_i              (now_us_i),
    .event_reason_i        (event_reason_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .percentile_value_us_o (percentile_value_us_o),
    .received_count_o      (received_count_o),
    .max_rtt_o             (max_rtt_o),
    .reconnect_count_o     (reconnect_count_o),
    .recovered_o           (recovered_o),
    .downtime_us_o         (downtime_us_o),
    .recovered_reason_o    (recovered_reason_o),
    .outage_opened_o       (outage_opened_o)
  );

  // Shadow copy of the monitor state.
  logic [31:0] hist_counts [lhm_pkg::BINS];
  logic [31:0] echo_total;
  logic [31:0] rtt_high;
  logic        echo_seen;
  logic        outage_active;
  logic [51:0] outage_start;
  logic [1:0]  open_cause;
  logic [31:0] reconnect_total;

  monitor_stats_t awaited_stats [$];
  logic [51:0]    wall_clock_us;
  int unsigned    mismatch_count = 0;
  int unsigned    result_index   = 0;
  int unsigned    cycle_count    = 0;
  int unsigned    src_gap_max    = 10;
  int unsigned    sink_gap_max   = 10;
  int unsigned    sink_hold_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void clear_monitor_state();
    foreach (hist_counts[i]) hist_counts[i] = '0;
    echo_total      = '0;
    rtt_high        = '0;
    echo_seen       = 1'b0;
    outage_active   = 1'b0;
    outage_start    = '0;
    open_cause      = '0;
    reconnect_total = '0;
  endfunction

  // Applies one item to the shadow state and returns the stats it should produce.
  function automatic monitor_stats_t update_monitor(probe_item_t it);
    monitor_stats_t s;
    int unsigned    bin;
    logic [63:0]    goal;
    logic [63:0]    running;
    logic           found;
    s = '0;
    case (it.op)
      lhm_pkg::OP_RECORD: begin
        bin = it.rtt / lhm_pkg::BIN_WIDTH_US;
        if (bin > lhm_pkg::BINS - 1) bin = lhm_pkg::BINS - 1;
        echo_total = echo_total + 32'd1;
        echo_seen  = 1'b1;
        if (it.rtt > rtt_high) rtt_high = it.rtt;
        hist_counts[bin] = hist_counts[bin] + 32'd1;
        if (outage_active) begin
          reconnect_total = reconnect_total + 32'd1;
          s.recovered     = 1'b1;
          s.downtime      = it.now - outage_start;
          s.rec_reason    = open_cause;
          outage_active   = 1'b0;
        end
      end
      lhm_pkg::OP_OUTAGE: begin
        if (echo_seen && !outage_active) begin
          outage_active = 1'b1;
          outage_start  = it.now;
          open_cause    = it.reason;
          s.opened      = 1'b1;
        end
      end
      lhm_pkg::OP_QUERY: begin
        if (echo_total != 0) begin
          // The target is the ceiling of total * percent / 100, kept wide.
          goal    = (64'(echo_total) * 64'(it.pct) + 64'd99) / 64'd100;
          running = '0;
          found   = 1'b0;
          for (int unsigned i = 0; i < lhm_pkg::BINS && !found; i++) begin
            running = running + 64'(hist_counts[i]);
            if (running >= goal) begin
              s.pctl_us = 32'(64'(i) * 64'(lhm_pkg::BIN_WIDTH_US));
              found     = 1'b1;
            end
          end
          if (!found) s.pctl_us = rtt_high;
        end
      end
      default: ;
    endcase
    s.rx_count   = echo_total;
    s.peak_rtt   = rtt_high;
    s.reconnects = reconnect_total;
    return s;
  endfunction

  function automatic probe_item_t probe(input logic [1:0] op, input logic [31:0] seq,
                                        input logic [31:0] rtt, input logic [6:0] pct,
                                        input logic [51:0] now, input logic [1:0] reason);
    probe_item_t it;
    it.op     = op;
    it.seq    = seq;
    it.rtt    = rtt;
    it.pct    = pct;
    it.now    = now;
    it.reason = reason;
    return it;
  endfunction

  // Mostly records on a running timer, with outages between them so that recoveries
  // happen often; some timestamps jump to arbitrary values.
  function automatic probe_item_t random_probe();
    probe_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      it.op = lhm_pkg::OP_RECORD;
    else if (pick < 72) it.op = lhm_pkg::OP_OUTAGE;
    else if (pick < 95) it.op = lhm_pkg::OP_QUERY;
    else                it.op = OP_UNUSED;
    it.seq = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70)      it.rtt = $urandom_range(0, 20000);
    else if (pick < 90) it.rtt = $urandom_range(0, 1100000);
    else if (pick < 99) it.rtt = $urandom_range(998000, 1002000);
    else                it.rtt = $urandom;
    it.pct = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, 100));
    if ($urandom_range(0, 9) == 0) begin
      it.now = 52'({$urandom, $urandom});
    end else begin
      wall_clock_us = wall_clock_us + 52'($urandom_range(0, 200000));
      it.now = wall_clock_us;
    end
    it.reason = 2'($urandom_range(0, 3));
    return it;
  endfunction

  task automatic send_item(input probe_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= it.op;
    seq_i          <= it.seq;
    rtt_us_i       <= it.rtt;
    percent_i      <= it.pct;
    now_us_i       <= it.now;
    event_reason_i <= it.reason;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_stats.push_back(update_monitor(it));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_stats.size() != 0);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                result_index, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : stats_check
    monitor_stats_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_stats.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                  result_index));
      end else begin
        want = awaited_stats.pop_front();
        check_field("percentile_value_us", 64'(percentile_value_us_o), 64'(want.pctl_us));
        check_field("received_count", 64'(received_count_o), 64'(want.rx_count));
        check_field("max_rtt", 64'(max_rtt_o), 64'(want.peak_rtt));
        check_field("reconnect_count", 64'(reconnect_count_o), 64'(want.reconnects));
        check_field("recovered", 64'(recovered_o), 64'(want.recovered));
        check_field("downtime_us", 64'(downtime_us_o), 64'(want.downtime));
        check_field("recovered_reason", 64'(recovered_reason_o), 64'(want.rec_reason));
        check_field("outage_opened", 64'(outage_opened_o), 64'(want.opened));
      end
      result_index++;
    end
  end

  // Receiver: waits a random number of cycles before taking each result, or a long
  // hold when one has been requested.
  initial begin : result_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, sink_gap_max);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("latency_histogram_monitor_core_tb NOT OK");
      $finish;
    end
  end

  task automatic test_empty_monitor();
    send_item(probe(lhm_pkg::OP_QUERY, 32'h1234_5678, 32'd4000, 7'd50, 52'd10,
                    RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd127, 52'd20, RSN_LINK_DOWN));
    // No match has been seen yet, so this outage must not open.
    send_item(probe(lhm_pkg::OP_OUTAGE, 32'd7, 32'd9, 7'd3, 52'd100, RSN_LINK_DOWN));
    send_item(probe(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, '1, RSN_UNDEFINED));
    wait_results_drained();
  endtask

  task automatic test_record_extremes();
    send_item(probe(lhm_pkg::OP_RECORD, 32'd0, 32'd0, 7'd0, 52'd0, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_RECORD, 32'hFFFF_FFFF, 32'd999, 7'd100, 52'd1,
                    RSN_UNDEFINED));
    send_item(probe(lhm_pkg::OP_RECORD, 32'd2, 32'd1000, 7'd0, 52'd2, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_RECORD, 32'd3, 32'd999_999, 7'd0, 52'd3, RSN_LINK_DOWN));
    // From here on the RTT lands in the last bin.
    send_item(probe(lhm_pkg::OP_RECORD, 32'd4, 32'd1_000_000, 7'd0, 52'd4, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_RECORD, 32'd5, 32'd1_000_999, 7'd0, 52'd5, RSN_LINK_DOWN));
    wait_results_drained();
  endtask

  task automatic test_outage_recovery();
    // An outage that starts at time zero is still a valid open outage.
    send_item(probe(lhm_pkg::OP_OUTAGE, 32'd0, 32'd0, 7'd0, 52'd0, RSN_UNDEFINED));
    send_item(probe(lhm_pkg::OP_OUTAGE, 32'd0, 32'd0, 7'd0, 52'd50, RSN_SEND_FAIL));
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd50, 52'd60, RSN_LINK_DOWN));
    send_item(probe(OP_UNUSED, 32'd0, 32'd0, 7'd0, 52'd70, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_RECORD, 32'd10, 32'd5000, 7'd0, 52'd777, RSN_LINK_DOWN));
    // Time going backwards makes the downtime wrap around.
    send_item(probe(lhm_pkg::OP_OUTAGE, 32'd0, 32'd0, 7'd0, '1, RSN_PROBE_TIMEOUT));
    send_item(probe(lhm_pkg::OP_RECORD, 32'd11, 32'd3000, 7'd0, 52'd5, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_OUTAGE, 32'd0, 32'd0, 7'd0, 52'd1000, RSN_SEND_FAIL));
    send_item(probe(lhm_pkg::OP_RECORD, 32'd12, 32'd42_000, 7'd0, 52'd2000,
                    RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_OUTAGE, 32'd0, 32'd0, 7'd0, 52'h8_0000_0000_0000,
                    RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_RECORD, 32'd13, 32'd1500, 7'd0, 52'hF_0000_0000_0001,
                    RSN_PROBE_TIMEOUT));
    wait_results_drained();
  endtask

  task automatic test_percentile_edges();
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd0, 52'd0, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd1, 52'd0, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd50, 52'd0, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd99, 52'd0, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd100, 52'd0, RSN_LINK_DOWN));
    // Above 100 percent the target is never met and the peak RTT comes back.
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd101, 52'd0, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd127, 52'd0, RSN_LINK_DOWN));
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_item(random_probe());
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    src_gap_max  = 0;
    sink_gap_max = 0;
    repeat (150) send_item(random_probe());
    wait_results_drained();
    src_gap_max  = 10;
    sink_gap_max = 10;
  endtask

  task automatic test_output_stall();
    // The receiver holds off long enough for the block to stop taking items.
    sink_hold_cycles = 400;
    src_gap_max = 0;
    repeat (30) send_item(random_probe());
    src_gap_max = 10;
    wait_results_drained();
  endtask

  task automatic test_peak_saturation();
    send_item(probe(lhm_pkg::OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, '1,
                    RSN_UNDEFINED));
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd100, 52'd0, RSN_LINK_DOWN));
    send_item(probe(lhm_pkg::OP_QUERY, 32'd0, 32'd0, 7'd127, 52'd0, RSN_LINK_DOWN));
    wait_results_drained();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    operation_i    <= lhm_pkg::OP_RECORD;
    seq_i          <= '0;
    rtt_us_i       <= '0;
    percent_i      <= '0;
    now_us_i       <= '0;
    event_reason_i <= RSN_LINK_DOWN;
    wall_clock_us   = '0;
    clear_monitor_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_monitor();
    test_record_extremes();
    test_outage_recovery();
    test_percentile_edges();
    test_random_traffic(700);
    test_back_to_back();
    test_output_stall();
    test_random_traffic(350);
    test_peak_saturation();

    // Any result still coming out now would be one with no item behind it.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_stats.size() == 0) begin
      $display("latency_histogram_monitor_core_tb OK");
    end else begin
      $display("latency_histogram_monitor_core_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lhm_pkg.sv
rtl/lhm_ram.sv
rtl/latency_histogram_monitor_core.sv
tb/sv/latency_histogram_monitor_core_tb.sv
